### rtl/core/fbr_pkg.sv
`timescale 1ns / 1ps
package fbr_pkg;

  localparam int COORD_W      = 12;
  localparam int PIX_W        = 32;
  localparam int STORE_PIXELS = 65536;
  localparam int ADDR_W       = $clog2(STORE_PIXELS);
  localparam int SUM_W        = 2 * COORD_W + 1;

  localparam logic [COORD_W-1:0] STRIDE_RESET = COORD_W'(256);

  localparam logic REQ_CMD   = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    CMD_FILL  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_AND   = 3'd2,
    CMD_OR    = 3'd3,
    CMD_XOR   = 3'd4,
    CMD_NOT   = 3'd5,
    CMD_COPY  = 3'd6,
    CMD_READ  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_STREAM = 2'd1,
    STAT_DROPPED   = 2'd2
  } status_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

endpackage

### rtl/core/fbr_ram.sv
`timescale 1ns / 1ps
module fbr_ram (
  input  logic                      clk_i,
  input  fbr_pkg::mem_req_t         req_i,
  output logic [fbr_pkg::PIX_W-1:0] rdata_o
);
  import fbr_pkg::*;

  logic [PIX_W-1:0] mem [STORE_PIXELS];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_o <= mem[req_i.addr];
      end
    end
  end

endmodule

### rtl/core/fbr_addr.sv
`timescale 1ns / 1ps
module fbr_addr (
  input  logic                         clk_i,
  input  logic [fbr_pkg::COORD_W-1:0]  x_i,
  input  logic [fbr_pkg::COORD_W-1:0]  y_i,
  input  logic [fbr_pkg::COORD_W-1:0]  stride_i,
  output logic [fbr_pkg::ADDR_W-1:0]   addr_o,
  output logic                         in_store_o
);
  import fbr_pkg::*;

  logic [2*COORD_W-1:0] prod_q;
  logic [COORD_W-1:0]   x_q;
  logic [SUM_W-1:0]     sum;

  // register the product, then add and range-check combinationally
  always_ff @(posedge clk_i) begin
    prod_q <= {{COORD_W{1'b0}}, y_i} * {{COORD_W{1'b0}}, stride_i};
    x_q    <= x_i;
  end

  assign sum        = SUM_W'(prod_q) + SUM_W'(x_q);
  assign in_store_o = (sum < SUM_W'(STORE_PIXELS));
  assign addr_o     = sum[ADDR_W-1:0];

endmodule

### rtl/core/fbr_seq.sv
`timescale 1ns / 1ps
module fbr_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [2:0]                   command_i,
  input  logic [fbr_pkg::COORD_W-1:0]  dest_x_i,
  input  logic [fbr_pkg::COORD_W-1:0]  dest_y_i,
  input  logic [fbr_pkg::COORD_W-1:0]  src_x_i,
  input  logic [fbr_pkg::COORD_W-1:0]  src_y_i,
  input  logic [fbr_pkg::COORD_W-1:0]  rect_width_i,
  input  logic [fbr_pkg::COORD_W-1:0]  rect_height_i,
  input  logic [fbr_pkg::PIX_W-1:0]    pixel_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fbr_pkg::PIX_W-1:0]    read_data_o,
  output logic                         last_o,
  output logic [1:0]                   status_o,
  output logic [fbr_pkg::COORD_W-1:0]  coord_x_o,
  output logic [fbr_pkg::COORD_W-1:0]  coord_y_o,
  input  logic [fbr_pkg::ADDR_W-1:0]   addr_i,
  input  logic                         in_store_i,
  output fbr_pkg::mem_req_t            mem_req_o,
  input  logic [fbr_pkg::PIX_W-1:0]    mem_rdata_i
);
  import fbr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RMW  = 3'd4;
  localparam logic [2:0] S_CPW  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  function automatic logic [PIX_W-1:0] combine(cmd_e mode, logic [PIX_W-1:0] old,
                                               logic [PIX_W-1:0] src);
    logic [PIX_W-1:0] res;
    unique case (mode)
      CMD_AND: res = old & src;
      CMD_OR:  res = old | src;
      CMD_XOR: res = old ^ src;
      CMD_NOT: res = ~src;
      default: res = src;
    endcase
    return res;
  endfunction

  logic [2:0]         state_q, state_d;
  logic               stream_open_q, stream_open_d;
  cmd_e               mode_q, mode_d;
  logic [COORD_W-1:0] cur_x_q, cur_x_d;
  logic [COORD_W-1:0] cur_y_q, cur_y_d;
  logic [COORD_W-1:0] org_x_q, org_x_d;
  logic [COORD_W-1:0] end_x_q, end_x_d;
  logic [COORD_W-1:0] rows_q, rows_d;
  logic [COORD_W-1:0] i_q, i_d;
  logic [COORD_W-1:0] j_q, j_d;
  logic               phase_q, phase_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;

  logic               req_q, req_d;
  cmd_e               cmd_q, cmd_d;
  logic [COORD_W-1:0] bx_q, bx_d, by_q, by_d, sx_q, sx_d, sy_q, sy_d;
  logic [COORD_W-1:0] w_q, w_d, h_q, h_d;
  logic [PIX_W-1:0]   pv_q, pv_d;
  logic [ADDR_W-1:0]  addr_q, addr_d, src_q, src_d;
  logic [PIX_W-1:0]   res_rd_q, res_rd_d;
  logic               res_last_q, res_last_d;
  status_e            res_status_q, res_status_d;
  logic [PIX_W-1:0]   out_rd_q, out_rd_d;
  logic               out_last_q, out_last_d;
  status_e            out_status_q, out_status_d;

  logic               step;
  cmd_e               cmd_in;

  assign cmd_in      = cmd_e'(command_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign last_o      = out_last_q;
  assign status_o    = out_status_q;

  always_comb begin
    if (req_q == REQ_PIXEL) begin
      coord_x_o = cur_x_q;
      coord_y_o = cur_y_q;
    end else if (cmd_q == CMD_READ) begin
      coord_x_o = bx_q;
      coord_y_o = by_q;
    end else if (cmd_q == CMD_COPY && !phase_q) begin
      coord_x_o = sx_q + i_q;
      coord_y_o = sy_q + j_q;
    end else begin
      coord_x_o = bx_q + i_q;
      coord_y_o = by_q + j_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    stream_open_d = stream_open_q;
    mode_d        = mode_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    org_x_d       = org_x_q;
    end_x_d       = end_x_q;
    rows_d        = rows_q;
    i_d           = i_q;
    j_d           = j_q;
    phase_d       = phase_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q;
    req_d         = req_q;
    cmd_d         = cmd_q;
    bx_d          = bx_q;
    by_d          = by_q;
    sx_d          = sx_q;
    sy_d          = sy_q;
    w_d           = w_q;
    h_d           = h_q;
    pv_d          = pv_q;
    addr_d        = addr_q;
    src_d         = src_q;
    res_rd_d      = res_rd_q;
    res_last_d    = res_last_q;
    res_status_d  = res_status_q;
    out_rd_d      = out_rd_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;
    mem_req_o     = '0;
    step          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = req_type_i;
          cmd_d        = cmd_in;
          bx_d         = dest_x_i;
          by_d         = dest_y_i;
          sx_d         = src_x_i;
          sy_d         = src_y_i;
          w_d          = rect_width_i;
          h_d          = rect_height_i;
          pv_d         = pixel_value_i;
          res_rd_d     = '0;
          res_last_d   = 1'b0;
          res_status_d = STAT_OK;
          if (req_type_i == REQ_PIXEL) begin
            if (!stream_open_q) begin
              res_status_d = STAT_NO_STREAM;
              state_d      = S_RESP;
            end else begin
              state_d = S_MUL;
            end
          end else if (cmd_in == CMD_READ) begin
            state_d = S_MUL;
          end else if (rect_width_i == '0 || rect_height_i == '0) begin
            res_last_d = 1'b1;
            state_d    = S_RESP;
          end else if (cmd_in == CMD_FILL || cmd_in == CMD_COPY) begin
            i_d     = '0;
            j_d     = '0;
            err_d   = 1'b0;
            phase_d = 1'b0;
            state_d = S_MUL;
          end else begin
            // open a stream, replacing any that is open
            stream_open_d = 1'b1;
            mode_d        = cmd_in;
            cur_x_d       = dest_x_i;
            cur_y_d       = dest_y_i;
            org_x_d       = dest_x_i;
            end_x_d       = dest_x_i + rect_width_i;
            rows_d        = rect_height_i;
            state_d       = S_RESP;
          end
        end
      end
      S_MUL: begin
        state_d = S_IDX;
      end
      S_IDX: begin
        if (req_q == REQ_PIXEL) begin
          if (cur_x_q + COORD_W'(1) == end_x_q) begin
            cur_x_d = org_x_q;
            cur_y_d = cur_y_q + COORD_W'(1);
            rows_d  = rows_q - COORD_W'(1);
            if (rows_q == COORD_W'(1)) begin
              stream_open_d = 1'b0;
              res_last_d    = 1'b1;
            end
          end else begin
            cur_x_d = cur_x_q + COORD_W'(1);
          end
          if (in_store_i) begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = addr_i;
            addr_d         = addr_i;
            state_d        = S_RMW;
          end else begin
            res_status_d = STAT_DROPPED;
            state_d      = S_RESP;
          end
        end else if (cmd_q == CMD_READ) begin
          res_last_d = 1'b1;
          if (in_store_i) begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = addr_i;
            state_d        = S_RD;
          end else begin
            res_status_d = STAT_DROPPED;
            state_d      = S_RESP;
          end
        end else if (cmd_q == CMD_FILL) begin
          if (in_store_i) begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = addr_i;
            mem_req_o.wdata = pv_q;
          end else begin
            err_d = 1'b1;
          end
          step = 1'b1;
        end else if (!phase_q) begin
          // copy: source index first, then destination
          if (in_store_i) begin
            src_d   = addr_i;
            phase_d = 1'b1;
            state_d = S_MUL;
          end else begin
            err_d = 1'b1;
            step  = 1'b1;
          end
        end else begin
          phase_d = 1'b0;
          if (in_store_i) begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = src_q;
            addr_d         = addr_i;
            state_d        = S_CPW;
          end else begin
            err_d = 1'b1;
            step  = 1'b1;
          end
        end
      end
      S_RD: begin
        res_rd_d = mem_rdata_i;
        state_d  = S_RESP;
      end
      S_RMW: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = combine(mode_q, mem_rdata_i, pv_q);
        state_d         = S_RESP;
      end
      S_CPW: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = mem_rdata_i;
        step            = 1'b1;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_rd_d     = res_rd_q;
          out_last_d   = res_last_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // advance the rectangle walk: columns first, then rows
    if (step) begin
      if (i_q == w_q - COORD_W'(1)) begin
        i_d = '0;
        if (j_q == h_q - COORD_W'(1)) begin
          res_last_d   = 1'b1;
          res_status_d = err_d ? STAT_DROPPED : STAT_OK;
          state_d      = S_RESP;
        end else begin
          j_d     = j_q + COORD_W'(1);
          state_d = S_MUL;
        end
      end else begin
        i_d     = i_q + COORD_W'(1);
        state_d = S_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      stream_open_q <= 1'b0;
      mode_q        <= CMD_FILL;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      org_x_q       <= '0;
      end_x_q       <= '0;
      rows_q        <= '0;
      i_q           <= '0;
      j_q           <= '0;
      phase_q       <= 1'b0;
      err_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      req_q         <= REQ_CMD;
      cmd_q         <= CMD_FILL;
    end else begin
      state_q       <= state_d;
      stream_open_q <= stream_open_d;
      mode_q        <= mode_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      org_x_q       <= org_x_d;
      end_x_q       <= end_x_d;
      rows_q        <= rows_d;
      i_q           <= i_d;
      j_q           <= j_d;
      phase_q       <= phase_d;
      err_q         <= err_d;
      out_valid_q   <= out_valid_d;
      req_q         <= req_d;
      cmd_q         <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q         <= bx_d;
    by_q         <= by_d;
    sx_q         <= sx_d;
    sy_q         <= sy_d;
    w_q          <= w_d;
    h_q          <= h_d;
    pv_q         <= pv_d;
    addr_q       <= addr_d;
    src_q        <= src_d;
    res_rd_q     <= res_rd_d;
    res_last_q   <= res_last_d;
    res_status_q <= res_status_d;
    out_rd_q     <= out_rd_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

endmodule

### rtl/core/framebuffer_rect_blitter_unit.sv
`timescale 1ns / 1ps
// 2D blit engine over a single-port store of 65536 32-bit pixels, pixel (x,y) at
// y*row_stride+x. Items are taken one at a time; the result sits in an output
// register so the next item is accepted while it waits. Every pixel access goes
// through one shared address unit (multiply, then add and range check) and the one
// store port, which sets the cost: a streamed pixel takes an index, a store read and
// a write-back; a read pixel an index and a read; a fill pixel an index and a write;
// a copy pixel a source index, a destination index with the source read, and a write;
// commands that touch no pixel go straight to the result. A pixel whose index lies
// beyond the store skips its store access; a copy source beyond it skips the rest.
// The store needs no clearing after reset; pixels never written read back undefined.
module framebuffer_rect_blitter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [2:0]                   command_i,
  input  logic [fbr_pkg::COORD_W-1:0]  dest_x_i,
  input  logic [fbr_pkg::COORD_W-1:0]  dest_y_i,
  input  logic [fbr_pkg::COORD_W-1:0]  src_x_i,
  input  logic [fbr_pkg::COORD_W-1:0]  src_y_i,
  input  logic [fbr_pkg::COORD_W-1:0]  rect_width_i,
  input  logic [fbr_pkg::COORD_W-1:0]  rect_height_i,
  input  logic [fbr_pkg::PIX_W-1:0]    pixel_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fbr_pkg::PIX_W-1:0]    read_data_o,
  output logic                         last_o,
  output logic [1:0]                   status_o
);
  import fbr_pkg::*;

  logic [COORD_W-1:0] stride_q, stride_d;
  logic               stride_sel;
  logic [COORD_W-1:0] coord_x, coord_y;
  logic [ADDR_W-1:0]  addr;
  logic               in_store;
  mem_req_t           mem_req;
  logic [PIX_W-1:0]   mem_rdata;

  assign pready     = 1'b1;
  assign stride_sel = (paddr[2] == 1'b0);

  always_comb begin
    stride_d = stride_q;
    if (psel && penable && pwrite && stride_sel) begin
      stride_d = pwdata[COORD_W-1:0];
    end
  end

  assign prdata = stride_sel ? {{(32-COORD_W){1'b0}}, stride_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
    end else begin
      stride_q <= stride_d;
    end
  end

  fbr_addr u_addr (
    .clk_i      (clk_i),
    .x_i        (coord_x),
    .y_i        (coord_y),
    .stride_i   (stride_q),
    .addr_o     (addr),
    .in_store_o (in_store)
  );

  fbr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  fbr_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .command_i     (command_i),
    .dest_x_i      (dest_x_i),
    .dest_y_i      (dest_y_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .coord_x_o     (coord_x),
    .coord_y_o     (coord_y),
    .addr_i        (addr),
    .in_store_i    (in_store),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fbr_pkg::*;

  localparam logic [2:0] REG_ROW_STRIDE = 3'd0;
  localparam int WATCHDOG_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic               req;
    cmd_e               cmd;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [PIX_W-1:0]   pv;
  } blit_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] rd;
    logic             last;
    status_e          status;
  } blit_result_t;

  typedef struct {
    blit_item_t   item;
    bit           typed;
    blit_result_t want;
  } dir_row_t;

  localparam blit_result_t NO_FIXED = '{32'h0, 1'b0, STAT_OK};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i = 1'b0;
  logic [2:0]           command_i = '0;
  logic [COORD_W-1:0]   dest_x_i = '0;
  logic [COORD_W-1:0]   dest_y_i = '0;
  logic [COORD_W-1:0]   src_x_i = '0;
  logic [COORD_W-1:0]   src_y_i = '0;
  logic [COORD_W-1:0]   rect_width_i = '0;
  logic [COORD_W-1:0]   rect_height_i = '0;
  logic [PIX_W-1:0]     pixel_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     read_data_o;
  logic                 last_o;
  logic [1:0]           status_o;

  // Shadow of the block's state
  bit [PIX_W-1:0]     frame_model [STORE_PIXELS];
  logic [COORD_W-1:0] row_stride_q = STRIDE_RESET;
  bit                 strm_open = 1'b0;
  cmd_e               strm_mode = CMD_FILL;
  logic [COORD_W-1:0] cur_x = '0;
  logic [COORD_W-1:0] cur_y = '0;
  logic [COORD_W-1:0] org_x = '0;
  logic [COORD_W:0]   end_x = '0;
  logic [COORD_W-1:0] rows_left = '0;

  blit_result_t blit_results_due[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int dropped_seen = 0;
  int stray_seen = 0;
  int streams_closed = 0;
  int strides_used = 0;
  int send_idle_pct = 38;
  int recv_stall_pct = 38;
  bit hold_off_req = 1'b0;
  bit hold_issued = 1'b0;

  framebuffer_rect_blitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .command_i     (command_i),
    .dest_x_i      (dest_x_i),
    .dest_y_i      (dest_y_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit pix_index(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   output int unsigned idx);
    idx = int'(y) * int'(row_stride_q) + int'(x);
    return idx < STORE_PIXELS;
  endfunction

  function automatic logic [PIX_W-1:0] raster_op(input cmd_e mode, input logic [PIX_W-1:0] old,
                                                 input logic [PIX_W-1:0] src);
    case (mode)
      CMD_AND: return old & src;
      CMD_OR:  return old | src;
      CMD_XOR: return old ^ src;
      CMD_NOT: return ~src;
      default: return src;
    endcase
  endfunction

  // Apply one transaction to the shadow state and return the result it owes.
  function automatic blit_result_t apply_blit(input blit_item_t it);
    blit_result_t r;
    int unsigned di;
    int unsigned si;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] xd;
    logic [COORD_W-1:0] yd;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    bit src_ok;
    r = NO_FIXED;
    if (it.req == REQ_PIXEL) begin
      if (!strm_open) begin
        r.status = STAT_NO_STREAM;
      end else begin
        if (pix_index(cur_x, cur_y, di)) begin
          frame_model[di] = raster_op(strm_mode, frame_model[di], it.pv);
        end else begin
          r.status = STAT_DROPPED;
        end
        nx = cur_x + 12'd1;
        if (nx == end_x[COORD_W-1:0]) begin
          cur_x = org_x;
          cur_y = cur_y + 12'd1;
          rows_left = rows_left - 12'd1;
          if (rows_left == 0) begin
            strm_open = 1'b0;
            r.last = 1'b1;
            streams_closed++;
          end
        end else begin
          cur_x = nx;
        end
      end
    end else if (it.cmd == CMD_READ) begin
      if (pix_index(it.dx, it.dy, di)) r.rd = frame_model[di];
      else r.status = STAT_DROPPED;
      r.last = 1'b1;
    end else if (it.w == 0 || it.h == 0) begin
      r.last = 1'b1;
    end else if (it.cmd == CMD_FILL || it.cmd == CMD_COPY) begin
      for (int j = 0; j < int'(it.h); j++) begin
        for (int i = 0; i < int'(it.w); i++) begin
          xd = it.dx + 12'(i);
          yd = it.dy + 12'(j);
          xs = it.sx + 12'(i);
          ys = it.sy + 12'(j);
          src_ok = (it.cmd == CMD_FILL) ? 1'b1 : pix_index(xs, ys, si);
          if (src_ok && pix_index(xd, yd, di)) begin
            frame_model[di] = (it.cmd == CMD_FILL) ? it.pv : frame_model[si];
          end else begin
            r.status = STAT_DROPPED;
          end
        end
      end
      r.last = 1'b1;
    end else begin
      strm_open = 1'b1;
      strm_mode = it.cmd;
      cur_x = it.dx;
      cur_y = it.dy;
      org_x = it.dx;
      end_x = {1'b0, it.dx} + {1'b0, it.w};
      rows_left = it.h;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] rnd12();
    return 12'($urandom_range(4095));
  endfunction

  function automatic blit_item_t cmd_item(input cmd_e c, input logic [COORD_W-1:0] dx,
                                          input logic [COORD_W-1:0] dy,
                                          input logic [COORD_W-1:0] sx,
                                          input logic [COORD_W-1:0] sy,
                                          input logic [COORD_W-1:0] w,
                                          input logic [COORD_W-1:0] h,
                                          input logic [PIX_W-1:0] pv);
    return '{REQ_CMD, c, dx, dy, sx, sy, w, h, pv};
  endfunction

  // Command and coordinate fields are don't-care on a pixel; randomize them.
  function automatic blit_item_t px_item(input logic [PIX_W-1:0] pv);
    return '{REQ_PIXEL, cmd_e'($urandom_range(7)), rnd12(), rnd12(), rnd12(), rnd12(),
             rnd12(), rnd12(), pv};
  endfunction

  function automatic dir_row_t typed_row(input blit_item_t it, input logic [PIX_W-1:0] rd,
                                         input logic lst, input status_e st);
    dir_row_t r;
    r.item = it;
    r.typed = 1'b1;
    r.want = '{rd, lst, st};
    return r;
  endfunction

  function automatic dir_row_t model_row(input blit_item_t it);
    dir_row_t r;
    r.item = it;
    r.typed = 1'b0;
    r.want = NO_FIXED;
    return r;
  endfunction

  // Mostly land inside the store for the current stride; now and then wrap or go anywhere.
  function automatic void pick_spot(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    int unsigned ymax;
    ymax = (row_stride_q == 0) ? 4095 : 50000 / int'(row_stride_q);
    if (ymax > 4095) ymax = 4095;
    case ($urandom_range(9))
      0: begin
        x = rnd12();
        y = rnd12();
      end
      1: begin
        x = 12'($urandom_range(4088, 4095));
        y = 12'($urandom_range(ymax));
      end
      default: begin
        x = rnd12();
        y = 12'($urandom_range(ymax));
      end
    endcase
  endfunction

  function automatic void pick_size(output logic [COORD_W-1:0] w, output logic [COORD_W-1:0] h);
    int r;
    r = $urandom_range(99);
    if (r < 2) begin
      w = 12'($urandom_range(2048, 4095));
      h = 12'($urandom_range(1, 2));
    end else if (r < 4) begin
      w = 12'd1;
      h = 12'($urandom_range(2048, 4095));
    end else begin
      w = 12'($urandom_range(1, 8));
      h = 12'($urandom_range(1, 8));
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  task automatic send_item(input blit_item_t it, input bit typed, input blit_result_t fixed);
    blit_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= it.req;
    command_i <= it.cmd;
    dest_x_i <= it.dx;
    dest_y_i <= it.dy;
    src_x_i <= it.sx;
    src_y_i <= it.sy;
    rect_width_i <= it.w;
    rect_height_i <= it.h;
    pixel_value_i <= it.pv;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_blit(it);
    blit_results_due.push_back(typed ? fixed : r);
    items_sent++;
  endtask

  // Drop valid and wait for every owed result, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (blit_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_stride(input logic [COORD_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ROW_STRIDE;
    pwdata <= {20'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    row_stride_q = v;
    strides_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {20'h0, v}) note_mismatch("row_stride readback", {20'h0, v}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int n, input bit with_hold);
    int first;
    int npix;
    int pick;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    first = items_sent;
    while (items_sent - first < n) begin
      if (with_hold && !hold_issued && items_sent - first >= n / 2) begin
        hold_off_req = 1'b1;
        hold_issued = 1'b1;
      end
      pick = $urandom_range(99);
      pick_spot(x, y);
      if (pick < 40) begin
        w = ($urandom_range(19) == 0) ? 12'($urandom_range(7, 40)) : 12'($urandom_range(1, 6));
        h = 12'($urandom_range(1, 4));
        send_item(cmd_item(cmd_e'($urandom_range(int'(CMD_WRITE), int'(CMD_NOT))), x, y,
                           rnd12(), rnd12(), w, h, $urandom), 1'b0, NO_FIXED);
        npix = int'(w) * int'(h);
        // cut the stream short now and then
        if ($urandom_range(9) == 0) npix = $urandom_range(npix - 1);
        for (int k = 0; k < npix; k++) begin
          if ($urandom_range(29) == 0) begin
            send_item(cmd_item(CMD_READ, x, y, rnd12(), rnd12(), rnd12(), rnd12(), $urandom),
                      1'b0, NO_FIXED);
          end
          send_item(px_item($urandom), 1'b0, NO_FIXED);
        end
      end else if (pick < 57) begin
        pick_size(w, h);
        send_item(cmd_item(CMD_FILL, x, y, rnd12(), rnd12(), w, h, $urandom), 1'b0, NO_FIXED);
      end else if (pick < 72) begin
        pick_size(w, h);
        pick_spot(sx, sy);
        send_item(cmd_item(CMD_COPY, x, y, sx, sy, w, h, $urandom), 1'b0, NO_FIXED);
      end else if (pick < 87) begin
        send_item(cmd_item(CMD_READ, x, y, rnd12(), rnd12(), rnd12(), rnd12(), $urandom),
                  1'b0, NO_FIXED);
      end else if (pick < 93) begin
        send_item(px_item($urandom), 1'b0, NO_FIXED);
      end else begin
        case ($urandom_range(2))
          0: begin
            w = 12'd0;
            h = rnd12();
          end
          1: begin
            w = rnd12();
            h = 12'd0;
          end
          default: begin
            w = 12'd0;
            h = 12'd0;
          end
        endcase
        send_item(cmd_item(cmd_e'($urandom_range(int'(CMD_FILL), int'(CMD_COPY))), x, y,
                           rnd12(), rnd12(), w, h, $urandom), 1'b0, NO_FIXED);
      end
    end
  endtask

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    blit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (status_o == STAT_DROPPED) dropped_seen++;
      if (status_o == STAT_NO_STREAM) stray_seen++;
      if (blit_results_due.size() == 0) begin
        note_mismatch("unexpected result, read_data", 32'h0, read_data_o);
      end else begin
        want = blit_results_due.pop_front();
        if (read_data_o !== want.rd) note_mismatch("read_data", want.rd, read_data_o);
        if (last_o !== want.last) note_mismatch("last", 32'(want.last), 32'(last_o));
        if (status_o !== want.status) note_mismatch("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    dir_row_t steps[$];
    logic [COORD_W-1:0] stride_plan [6];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // 256x256 at the reset stride writes every pixel, so no later read sees an unwritten one.
    steps.push_back(typed_row(cmd_item(CMD_FILL, 0, 0, 0, 0, 256, 256, 32'hA5A5_0F0F),
                              32'h0, 1'b1, STAT_OK));
    steps.push_back(typed_row(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0),
                              32'hA5A5_0F0F, 1'b1, STAT_OK));
    steps.push_back(typed_row(cmd_item(CMD_READ, 4095, 4095, 4095, 4095, 4095, 4095,
                                       32'hFFFF_FFFF), 32'h0, 1'b1, STAT_DROPPED));
    steps.push_back(typed_row(px_item(32'h1234_5678), 32'h0, 1'b0, STAT_NO_STREAM));
    steps.push_back(typed_row(cmd_item(CMD_FILL, 4, 4, 0, 0, 0, 7, 32'hDEAD_BEEF),
                              32'h0, 1'b1, STAT_OK));
    steps.push_back(typed_row(cmd_item(CMD_COPY, 4, 4, 9, 9, 5, 0, 0), 32'h0, 1'b1, STAT_OK));
    steps.push_back(model_row(cmd_item(CMD_FILL, 0, 10, 0, 0, 4095, 1, 32'hFFFF_FFFF)));
    steps.push_back(model_row(cmd_item(CMD_FILL, 3, 0, 0, 0, 1, 4095, 32'h0)));
    // overlapping copy one column right: each pixel sees the one just written
    steps.push_back(model_row(cmd_item(CMD_COPY, 1, 10, 0, 10, 8, 1, 0)));
    steps.push_back(model_row(cmd_item(CMD_COPY, 0, 20, 0, 300, 2, 2, 0)));
    steps.push_back(model_row(cmd_item(CMD_READ, 5, 10, 0, 0, 0, 0, 0)));
    // stream that wraps the column back to zero
    steps.push_back(typed_row(cmd_item(CMD_WRITE, 4094, 30, 0, 0, 3, 2, 0),
                              32'h0, 1'b0, STAT_OK));
    for (int k = 0; k < 6; k++) steps.push_back(model_row(px_item(32'h0101_0101 * k)));
    steps.push_back(typed_row(cmd_item(CMD_AND, 0, 40, 0, 0, 1, 1, 0), 32'h0, 1'b0, STAT_OK));
    steps.push_back(model_row(px_item(32'h0F0F_00FF)));
    // an open stream is replaced by the next stream command
    steps.push_back(typed_row(cmd_item(CMD_OR, 0, 41, 0, 0, 2, 1, 0), 32'h0, 1'b0, STAT_OK));
    steps.push_back(typed_row(cmd_item(CMD_XOR, 0, 42, 0, 0, 1, 1, 0), 32'h0, 1'b0, STAT_OK));
    steps.push_back(model_row(px_item(32'hFFFF_0000)));
    steps.push_back(typed_row(cmd_item(CMD_NOT, 4095, 4095, 0, 0, 1, 1, 0),
                              32'h0, 1'b0, STAT_OK));
    steps.push_back(typed_row(px_item(32'h5555_AAAA), 32'h0, 1'b1, STAT_DROPPED));
    steps.push_back(model_row(cmd_item(CMD_READ, 0, 42, 0, 0, 0, 0, 0)));
    foreach (steps[k]) send_item(steps[k].item, steps[k].typed, steps[k].want);

    stride_plan = '{12'd1, 12'd4095, 12'd0, 12'($urandom_range(2, 4094)), 12'd256, 12'd17};
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph == 2) ? 0 : 38;
      recv_stall_pct = (ph == 2) ? 0 : 38;
      drain();
      program_stride(stride_plan[ph]);
      run_random(PHASE_ITEMS, ph == 1);
    end
    drain();

    $display("Sent %0d item transactions over %0d row-stride settings, zero and both ends included.",
             items_sent, strides_used + 1);
    $display("Checked %0d results: %0d with dropped pixels, %0d stray pixels, %0d streams closed.",
             results_seen, dropped_seen, stray_seen, streams_closed);
    if (mismatches == 0 && blit_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### framebuffer_rect_blitter_unit.f
rtl/core/fbr_pkg.sv
rtl/core/fbr_ram.sv
rtl/core/fbr_addr.sv
rtl/core/fbr_seq.sv
rtl/core/framebuffer_rect_blitter_unit.sv
sim/tb_top.sv
